>>> hw/rtl/cple_pkg.sv
// ----------------------------------------------------------------------------
// cple_pkg: shared types and codes for the circular list position engine
// Request and status codes, stream payload widths and the control structs
// that pass between the sequencer and its two memories.
// ----------------------------------------------------------------------------
package cple_pkg;

  // payload field widths
  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INS_FIRST = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_LAST  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_COUNT     = 3'd6;
  localparam logic [REQ_W-1:0] REQ_LIST_ALL  = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // node store strobes
  typedef struct packed {
    logic rd_en;
    logic val_we;
    logic link_we;
  } ns_ctrl_t;

  // free stack strobes
  typedef struct packed {
    logic pop;
    logic push;
  } fs_ctrl_t;

endpackage

>>> hw/rtl/cple_node_store.sv
// ----------------------------------------------------------------------------
// cple_node_store: node value and next-link memories
// Two arrays sharing one read address, one write port each, registered read.
// ----------------------------------------------------------------------------
module cple_node_store #(
  parameter int CAPACITY = 32
) (
  input  logic                           clk,
  input  cple_pkg::ns_ctrl_t             ctrl,
  input  logic [$clog2(CAPACITY)-1:0]    rd_addr,
  input  logic [$clog2(CAPACITY)-1:0]    val_waddr,
  input  logic signed [cple_pkg::VAL_W-1:0] val_wdata,
  input  logic [$clog2(CAPACITY)-1:0]    link_waddr,
  input  logic [$clog2(CAPACITY)-1:0]    link_wdata,
  output logic signed [cple_pkg::VAL_W-1:0] rd_val,
  output logic [$clog2(CAPACITY)-1:0]    rd_link
);

  localparam int IW = $clog2(CAPACITY);

  logic signed [cple_pkg::VAL_W-1:0] val_mem [CAPACITY];
  logic [IW-1:0]                     link_mem [CAPACITY];
  logic signed [cple_pkg::VAL_W-1:0] rd_val_r;
  logic [IW-1:0]                     rd_link_r;

  always_ff @(posedge clk) begin
    if (ctrl.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_val_r  <= val_mem[rd_addr];
      rd_link_r <= link_mem[rd_addr];
    end
  end

  assign rd_val  = rd_val_r;
  assign rd_link = rd_link_r;

endmodule

>>> hw/rtl/cple_free_stack.sv
// ----------------------------------------------------------------------------
// cple_free_stack: stack of free node slots
// Slot memory with a top pointer. A low-water mark stands in for the reset
// contents: entries below the lowest top ever reached still hold their own
// index, so those are answered from the index instead of the memory.
// ----------------------------------------------------------------------------
module cple_free_stack #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cple_pkg::fs_ctrl_t                ctrl,
  input  logic [$clog2(CAPACITY)-1:0]       push_slot,
  output logic [$clog2(CAPACITY)-1:0]       pop_slot,
  output logic [$clog2(CAPACITY+1)-1:0]     top
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] slot_mem [CAPACITY];
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] lwm_r, lwm_nxt;
  logic [CW-1:0] top_dec;
  logic [IW-1:0] q_r;
  logic [IW-1:0] idx_r;
  logic          use_mem_r;

  assign top_dec = top_r - CW'(1);

  always_comb begin
    top_nxt = top_r;
    lwm_nxt = lwm_r;
    if (ctrl.pop) begin
      top_nxt = top_dec;
      if (top_dec < lwm_r) begin
        lwm_nxt = top_dec;
      end
    end else if (ctrl.push) begin
      top_nxt = top_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= CW'(CAPACITY);
      lwm_r <= CW'(CAPACITY);
    end else begin
      top_r <= top_nxt;
      lwm_r <= lwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      slot_mem[top_r[IW-1:0]] <= push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      q_r       <= slot_mem[top_dec[IW-1:0]];
      idx_r     <= top_dec[IW-1:0];
      use_mem_r <= (top_dec >= lwm_r);
    end
  end

  assign pop_slot = use_mem_r ? q_r : idx_r;
  assign top      = top_r;

endmodule

>>> hw/rtl/circular_list_position_engine_top.sv
// ----------------------------------------------------------------------------
// circular_list_position_engine_top: circular linked list request engine
// Sequencer over a node store and a free-slot stack, with an output register.
// ----------------------------------------------------------------------------
// Requests enter on in_: in_tuser is the request code, in_tdata the value to
// insert and the 1-based position. Results leave on out_; out_tlast marks the
// final result of a request. One request at a time: in_tready is high only
// while the sequencer is idle, even if a result still waits in the output reg.
// Count, rejects and delete of the only entry answer directly; insert first /
// last and delete first write the node store; middle positional insert /
// delete walk toward the position (ends: as insert or delete first / last),
// and delete last walks the list to the entry before the tail. List all
// streams its values one a cycle while the receiver takes them.
// Walks follow one next link per cycle. in_tready returns as the final
// result loads into the output register.
// Reset (rst_n low, synchronous) empties the list and frees every slot; the
// free stack works from a low-water mark, so there is no clearing pass.
// A stalled receiver holds the output register; the sequencer waits and
// list-all resumes where it stopped.
// ----------------------------------------------------------------------------
module circular_list_position_engine_top #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [31:0] value, [37:32] position, [39:38] zero
  input  logic [cple_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: [2:0] req_type
  input  logic [cple_pkg::REQ_W-1:0]        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: [5:0] count, [37:6] item_value, [39:38] zero
  output logic [cple_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: [1:0] status
  output logic [cple_pkg::STAT_W-1:0]       out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // wide enough for position and size + 1 compares
  localparam int PW = ((CW > cple_pkg::POS_W) ? CW : cple_pkg::POS_W) + 1;
  localparam int PAD_W = cple_pkg::OUT_DATA_W - cple_pkg::CNT_W - cple_pkg::VAL_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WR1  = 8'b0000_0010,  // write new node, splice at an end
    S_WR2  = 8'b0000_0100,  // close the ring: link[tail] = head
    S_WALK = 8'b0000_1000,  // follow links toward the predecessor
    S_WR3  = 8'b0001_0000,  // link predecessor to new node
    S_VIC  = 8'b0010_0000,  // unlink the victim
    S_LIST = 8'b0100_0000,  // stream values out
    S_RESP = 8'b1000_0000   // single result
  } state_t;

  typedef enum logic [2:0] {
    OP_INS_FIRST,
    OP_INS_LAST,
    OP_INS_MID,
    OP_DEL_FIRST,
    OP_DEL_LAST,
    OP_DEL_MID
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] vic_r, vic_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic signed [cple_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic [cple_pkg::STAT_W-1:0]        stat_r, stat_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [cple_pkg::STAT_W-1:0]        out_stat_r, out_stat_nxt;
  logic [cple_pkg::CNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic signed [cple_pkg::VAL_W-1:0]  out_item_r, out_item_nxt;
  logic                               out_last_r, out_last_nxt;

  // request fields
  logic [cple_pkg::REQ_W-1:0]         in_req;
  logic signed [cple_pkg::VAL_W-1:0]  in_value;
  logic [cple_pkg::POS_W-1:0]         in_pos;
  logic [PW-1:0]                      pos_w;
  logic [PW-1:0]                      size_w;
  logic                               is_full;
  logic                               ins_bad;
  logic                               del_bad;
  logic                               out_free;

  // memory hookup
  cple_pkg::ns_ctrl_t                 ns_ctrl;
  logic [IW-1:0]                      rd_addr;
  logic [IW-1:0]                      val_waddr;
  logic [IW-1:0]                      link_waddr;
  logic [IW-1:0]                      link_wdata;
  logic signed [cple_pkg::VAL_W-1:0]  rd_val;
  logic [IW-1:0]                      rd_link;
  cple_pkg::fs_ctrl_t                 fs_ctrl;
  logic [IW-1:0]                      push_slot;
  logic [IW-1:0]                      fs_slot;
  logic [CW-1:0]                      fs_top;

  assign in_req   = in_tuser;
  assign in_value = in_tdata[cple_pkg::VAL_W-1:0];
  assign in_pos   = in_tdata[cple_pkg::VAL_W +: cple_pkg::POS_W];
  assign pos_w    = PW'(in_pos);
  assign size_w   = PW'(size_r);
  assign is_full  = (size_r == CW'(CAPACITY)) || (fs_top == '0);
  assign ins_bad  = (pos_w == '0) || (pos_w > size_w + PW'(1));
  assign del_bad  = (pos_w == '0) || (pos_w > size_w);
  assign out_free = !out_valid_r || out_tready;

  assign in_tready = (state_r == S_IDLE);

  cple_node_store #(
    .CAPACITY (CAPACITY)
  ) u_node_store (
    .clk        (clk),
    .ctrl       (ns_ctrl),
    .rd_addr    (rd_addr),
    .val_waddr  (val_waddr),
    .val_wdata  (val_r),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .rd_val     (rd_val),
    .rd_link    (rd_link)
  );

  cple_free_stack #(
    .CAPACITY (CAPACITY)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fs_ctrl),
    .push_slot (push_slot),
    .pop_slot  (fs_slot),
    .top       (fs_top)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    size_nxt  = size_r;
    cur_nxt   = cur_r;
    vic_nxt   = vic_r;
    steps_nxt = steps_r;
    k_nxt     = k_r;
    val_nxt   = val_r;
    stat_nxt  = stat_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    out_item_nxt  = out_item_r;
    out_last_nxt  = out_last_r;

    ns_ctrl    = '0;
    rd_addr    = cur_r;
    val_waddr  = fs_slot;
    link_waddr = tail_r;
    link_wdata = head_r;
    fs_ctrl    = '0;
    push_slot  = tail_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          val_nxt   = in_value;
          stat_nxt  = cple_pkg::ST_OK;
          state_nxt = S_RESP;
          unique case (in_req) inside
            cple_pkg::REQ_INS_FIRST, cple_pkg::REQ_INS_LAST,
            cple_pkg::REQ_INS_POS: begin
              // full is checked ahead of the position
              if (is_full) begin
                stat_nxt = cple_pkg::ST_FULL;
              end else if (in_req == cple_pkg::REQ_INS_POS && ins_bad) begin
                stat_nxt = cple_pkg::ST_BADPOS;
              end else begin
                fs_ctrl.pop = 1'b1;
                if (in_req == cple_pkg::REQ_INS_FIRST ||
                    (in_req == cple_pkg::REQ_INS_POS && pos_w == PW'(1))) begin
                  op_nxt    = OP_INS_FIRST;
                  state_nxt = S_WR1;
                end else if (in_req == cple_pkg::REQ_INS_LAST ||
                             pos_w == size_w + PW'(1)) begin
                  op_nxt    = OP_INS_LAST;
                  state_nxt = S_WR1;
                end else begin
                  op_nxt        = OP_INS_MID;
                  ns_ctrl.rd_en = 1'b1;
                  rd_addr       = head_r;
                  cur_nxt       = head_r;
                  steps_nxt     = CW'(pos_w - PW'(2));
                  state_nxt     = S_WALK;
                end
              end
            end
            cple_pkg::REQ_DEL_FIRST, cple_pkg::REQ_DEL_LAST,
            cple_pkg::REQ_DEL_POS: begin
              if (size_r == '0) begin
                stat_nxt = cple_pkg::ST_EMPTY;
              end else if (in_req == cple_pkg::REQ_DEL_POS && del_bad) begin
                stat_nxt = cple_pkg::ST_BADPOS;
              end else if (size_r == CW'(1)) begin
                // single entry: list becomes empty
                head_nxt     = '0;
                tail_nxt     = '0;
                push_slot    = tail_r;
                fs_ctrl.push = 1'b1;
                size_nxt     = size_r - CW'(1);
              end else begin
                ns_ctrl.rd_en = 1'b1;
                rd_addr       = head_r;
                cur_nxt       = head_r;
                state_nxt     = S_WALK;
                if (in_req == cple_pkg::REQ_DEL_FIRST ||
                    (in_req == cple_pkg::REQ_DEL_POS && pos_w == PW'(1))) begin
                  op_nxt    = OP_DEL_FIRST;
                  steps_nxt = '0;
                end else if (in_req == cple_pkg::REQ_DEL_LAST || pos_w == size_w) begin
                  op_nxt    = OP_DEL_LAST;
                  steps_nxt = size_r - CW'(2);
                end else begin
                  op_nxt    = OP_DEL_MID;
                  steps_nxt = CW'(pos_w - PW'(2));
                end
              end
            end
            cple_pkg::REQ_COUNT: begin
              stat_nxt = cple_pkg::ST_OK;
            end
            default: begin
              // list all
              if (size_r == '0) begin
                stat_nxt = cple_pkg::ST_EMPTY;
              end else begin
                ns_ctrl.rd_en = 1'b1;
                rd_addr       = head_r;
                k_nxt         = '0;
                state_nxt     = S_LIST;
              end
            end
          endcase
        end
      end

      S_WR1: begin
        ns_ctrl.val_we = 1'b1;
        val_waddr      = fs_slot;
        if (size_r == '0) begin
          head_nxt = fs_slot;
          tail_nxt = fs_slot;
        end else if (op_r == OP_INS_FIRST) begin
          ns_ctrl.link_we = 1'b1;
          link_waddr      = fs_slot;
          link_wdata      = head_r;
          head_nxt        = fs_slot;
        end else begin
          ns_ctrl.link_we = 1'b1;
          link_waddr      = tail_r;
          link_wdata      = fs_slot;
          tail_nxt        = fs_slot;
        end
        state_nxt = S_WR2;
      end

      S_WR2: begin
        ns_ctrl.link_we = 1'b1;
        link_waddr      = tail_r;
        link_wdata      = head_r;
        if (op_r == OP_INS_FIRST || op_r == OP_INS_LAST) begin
          size_nxt = size_r + CW'(1);
        end else begin
          size_nxt = size_r - CW'(1);
        end
        state_nxt = S_RESP;
      end

      S_WALK: begin
        // rd_link is the successor of cur_r
        if (steps_r == '0) begin
          case (op_r)
            OP_DEL_FIRST: begin
              head_nxt     = rd_link;
              push_slot    = cur_r;
              fs_ctrl.push = 1'b1;
              state_nxt    = S_WR2;
            end
            OP_DEL_LAST: begin
              tail_nxt     = cur_r;
              push_slot    = tail_r;
              fs_ctrl.push = 1'b1;
              state_nxt    = S_WR2;
            end
            OP_INS_MID: begin
              ns_ctrl.val_we  = 1'b1;
              val_waddr       = fs_slot;
              ns_ctrl.link_we = 1'b1;
              link_waddr      = fs_slot;
              link_wdata      = rd_link;
              state_nxt       = S_WR3;
            end
            default: begin
              // middle delete: fetch the victim's successor
              ns_ctrl.rd_en = 1'b1;
              rd_addr       = rd_link;
              vic_nxt       = rd_link;
              state_nxt     = S_VIC;
            end
          endcase
        end else begin
          ns_ctrl.rd_en = 1'b1;
          rd_addr       = rd_link;
          cur_nxt       = rd_link;
          steps_nxt     = steps_r - CW'(1);
        end
      end

      S_WR3: begin
        ns_ctrl.link_we = 1'b1;
        link_waddr      = cur_r;
        link_wdata      = fs_slot;
        size_nxt        = size_r + CW'(1);
        state_nxt       = S_RESP;
      end

      S_VIC: begin
        ns_ctrl.link_we = 1'b1;
        link_waddr      = cur_r;
        link_wdata      = rd_link;
        push_slot       = vic_r;
        fs_ctrl.push    = 1'b1;
        size_nxt        = size_r - CW'(1);
        state_nxt       = S_RESP;
      end

      S_LIST: begin
        // read data stays put while the output stalls
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = cple_pkg::ST_OK;
          out_cnt_nxt   = cple_pkg::CNT_W'(size_r);
          out_item_nxt  = rd_val;
          out_last_nxt  = (k_r == size_r - CW'(1));
          if (k_r == size_r - CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            ns_ctrl.rd_en = 1'b1;
            rd_addr       = rd_link;
            k_nxt         = k_r + CW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_cnt_nxt   = cple_pkg::CNT_W'(size_r);
          out_item_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cur_r      <= cur_nxt;
    vic_r      <= vic_nxt;
    steps_r    <= steps_nxt;
    k_r        <= k_nxt;
    val_r      <= val_nxt;
    stat_r     <= stat_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_item_r, out_cnt_r};

`ifndef NO_ASSERTIONS
  // between requests every slot is either in the list or on the free stack
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ((CW+1)'(size_r) + (CW+1)'(fs_top)) == (CW+1)'(CAPACITY))
    else $error("list size and free stack depth disagree");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fs_ctrl.pop |-> (fs_top != '0))
    else $error("pop from empty free stack");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fs_ctrl.push |-> (fs_top != CW'(CAPACITY)))
    else $error("push onto full free stack");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (size_r != '0))
    else $error("list streaming with empty list");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while busy");
`endif

endmodule
